@@ rtl/core/olad_pkg.sv @@
// Shared types and constants for the ordered list block.
// Depends on nothing; imported by olad_store and ordered_list_append_delete.
`timescale 1ns / 1ps

package olad_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_DISPLAY = 2'd1,
      OP_DELETE  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_FULL     = 3'd1,
      ST_DELETED  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_LISTED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LIST,
      S_DEL,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

@@ rtl/core/olad_store.sv @@
// Element memory: one write port, one read port, registered read data.
// Depends on olad_pkg for widths and the request struct.
`timescale 1ns / 1ps

module olad_store
   import olad_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ordered_list_append_delete.sv @@
// Top level of the ordered list block: control, length and result register.
// Depends on olad_pkg and olad_store.
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values, head at memory entry 0, up to CAPACITY
// entries. One request is worked at a time. Append writes the entry at the
// accept edge and moves to the reply state, which loads the reply into the
// result register once that register is free. Display issues one memory read
// per cycle and streams one element per cycle while the sink keeps rsp_tready
// high. Delete walks the whole list once, one read per cycle, whether or not a
// match exists, and moves every entry behind the match down by one as it
// passes (read entry k, write entry k-1). The single read port of the element
// memory sets these rates. The memory is not cleared after reset; only entries
// below the current length are ever read. A new request is taken even while
// the last result still waits in the result register.

module ordered_list_append_delete
   import olad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] op

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] item
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;          // next entry to read
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;    // entry held in rd_data
   logic              rd_pending_ff, rd_pending_in;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] val_ff, val_in;
   status_type        rep_status_ff, rep_status_in;
   logic [DATA_W-1:0] rep_item_ff, rep_item_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_item_ff, rsp_item_in;
   logic              rsp_last_ff, rsp_last_in;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;

   logic              accept;
   logic              full;
   logic              out_free;
   logic              consume;
   logic              issue;
   logic              match;
   logic              rd_last;

   olad_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------
   // Datapath controls and memory port
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      accept     = req_tvalid && req_tready;
      full       = (len_ff == CNT_W'(CAPACITY));
      out_free   = !rsp_valid_ff || rsp_tready;
      match      = (rd_data == val_ff);
      rd_last    = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == len_ff);

      // take the returned element: display waits for room in the result
      // register, delete takes it every cycle
      case (state_ff)
         S_LIST:  consume = rd_pending_ff && out_free;
         S_DEL:   consume = rd_pending_ff;
         default: consume = 1'b0;
      endcase

      // read the next entry once the data register frees up
      issue = ((state_ff == S_LIST) || (state_ff == S_DEL)) &&
              (cnt_ff < len_ff) && (!rd_pending_ff || consume);

      mem_req.rd_en   = issue;
      mem_req.rd_addr = cnt_ff[ADDR_W-1:0];

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = len_ff[ADDR_W-1:0];
      mem_req.wr_data = req_tdata;
      if (accept && (op_type'(req_tuser) == OP_APPEND) && !full) begin
         // store at the tail
         mem_req.wr_en = 1'b1;
      end else if ((state_ff == S_DEL) && consume && found_ff) begin
         // close the gap: move this entry down by one
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = rd_idx_ff - ADDR_W'(1);
         mem_req.wr_data = rd_data;
      end
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pending_in = rd_pending_ff;
      found_in      = found_ff;
      val_in        = val_ff;
      rep_status_in = rep_status_ff;
      rep_item_in   = rep_item_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in        = req_tdata;
               rep_item_in   = req_tdata;
               cnt_in        = '0;
               rd_pending_in = 1'b0;
               found_in      = 1'b0;
               case (op_type'(req_tuser))
                  OP_APPEND: begin
                     if (full) begin
                        rep_status_in = ST_FULL;
                     end else begin
                        rep_status_in = ST_ADDED;
                        len_in        = len_ff + CNT_W'(1);
                     end
                     state_in = S_REPLY;
                  end
                  OP_DISPLAY: begin
                     if (len_ff == '0) begin
                        rep_status_in = ST_EMPTY;
                        rep_item_in   = '0;
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  OP_DELETE: begin
                     if (len_ff == '0) begin
                        rep_status_in = ST_NOTFOUND;
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_DEL;
                     end
                  end
                  default: begin
                     // unused op code: drop it
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LIST: begin
            if (issue) begin
               cnt_in    = cnt_ff + CNT_W'(1);
               rd_idx_in = cnt_ff[ADDR_W-1:0];
            end
            rd_pending_in = issue || (rd_pending_ff && !consume);
            if (consume && rd_last) begin
               state_in = S_IDLE;
            end
         end
         S_DEL: begin
            if (issue) begin
               cnt_in    = cnt_ff + CNT_W'(1);
               rd_idx_in = cnt_ff[ADDR_W-1:0];
            end
            rd_pending_in = issue || (rd_pending_ff && !consume);
            if (consume) begin
               if (!found_ff && match) begin
                  found_in = 1'b1;
               end
               if (rd_last) begin
                  rep_item_in = val_ff;
                  if (found_ff || match) begin
                     rep_status_in = ST_DELETED;
                     len_in        = len_ff - CNT_W'(1);
                  end else begin
                     rep_status_in = ST_NOTFOUND;
                  end
                  state_in = S_REPLY;
               end
            end
         end
         S_REPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Result register: parts the sink from the list walk
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;

      if ((state_ff == S_REPLY) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rep_status_ff;
         rsp_item_in   = rep_item_ff;
         rsp_last_in   = 1'b1;
      end else if ((state_ff == S_LIST) && consume) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_LISTED;
         rsp_item_in   = rd_data;
         rsp_last_in   = rd_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      val_ff        <= val_in;
      rep_status_ff <= rep_status_in;
      rep_item_ff   <= rep_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   a_shift_below_len: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && (state_ff == S_DEL)) |-> (CNT_W'(mem_req.wr_addr) < len_ff))
      else $error("delete shift writes beyond the list");

   a_pending_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_pending_ff |-> ((state_ff == S_LIST) || (state_ff == S_DEL)))
      else $error("read data pending outside a list walk");
`endif

endmodule

@@ bench/ordered_list_append_delete_tb.sv @@
// Self-checking bench for ordered_list_append_delete: append, delete and display traffic.
// Depends on olad_pkg and the RTL of the block; predicts replies with its own list model.
`timescale 1ns / 1ps

module ordered_list_append_delete_tb;
   import olad_pkg::*;

   // Op code 3 has no member in op_type; the block ignores it.
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         ITEM_TARGET  = 430;
   localparam int         QUIET_TAIL   = 60;     // no idling once this few items remain
   localparam int         SETTLE_CYCLES = 100;   // longer than a full display walk
   localparam int         REPLY_WAIT   = 20000;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] value;
      logic        drain;   // hold this item until every pending reply has come back
   } list_cmd_type;

   typedef struct {
      status_type  status;
      logic [31:0] item;
      logic        last;
   } list_reply_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   list_cmd_type   pending_items[$];
   list_reply_type replies_due[$];
   logic [31:0] stored_vals[$];   // list contents as seen by accepted transfers
   int          counted_items;
   int          mismatches;
   logic        req_taken;
   int          send_gap;
   int          recv_gap;
   bit          idle_on;
   list_cmd_type   next_cmd;
   list_reply_type seen_reply;
   int          guard;

   ordered_list_append_delete u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic expect_reply(input status_type st, input logic [31:0] item, input logic last);
      list_reply_type r;
      r.status = st;
      r.item   = item;
      r.last   = last;
      replies_due.push_back(r);
   endtask

   // Apply one accepted transfer to the list and queue the replies it must produce.
   task automatic apply_list_op(input logic [1:0] op, input logic [31:0] value);
      int hit;
      hit = -1;
      case (op)
         OP_APPEND: begin
            if (stored_vals.size() >= CAPACITY) begin
               expect_reply(ST_FULL, value, 1'b1);
            end else begin
               stored_vals.push_back(value);
               expect_reply(ST_ADDED, value, 1'b1);
            end
         end
         OP_DISPLAY: begin
            if (stored_vals.size() == 0) begin
               expect_reply(ST_EMPTY, 32'd0, 1'b1);
            end else begin
               foreach (stored_vals[i])
                  expect_reply(ST_LISTED, stored_vals[i], i == stored_vals.size() - 1);
            end
         end
         OP_DELETE: begin
            // Search from the head; only the first match goes.
            foreach (stored_vals[i])
               if (hit < 0 && stored_vals[i] == value) hit = i;
            if (hit >= 0) begin
               stored_vals.delete(hit);
               expect_reply(ST_DELETED, value, 1'b1);
            end else begin
               expect_reply(ST_NOTFOUND, value, 1'b1);
            end
         end
         default: ;   // unused code: no state change, no reply
      endcase
   endtask

   task automatic add_item(input logic [1:0] op, input logic [31:0] value, input logic drain);
      list_cmd_type c;
      c.op    = op;
      c.value = value;
      c.drain = drain;
      pending_items.push_back(c);
      if (op != OP_UNUSED) counted_items++;
   endtask

   // Mostly a small pool so deletes find matches, some extremes, some full-range values.
   function automatic logic [31:0] pick_operand();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 15) - 8;
      if (r == 6) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom();
   endfunction

   // Enough appends to overflow the store from any level, then list it.
   task automatic queue_fill(input int extra);
      repeat (CAPACITY + extra) add_item(OP_APPEND, pick_operand(), 1'b0);
      add_item(OP_DISPLAY, 32'd0, 1'b1);
   endtask

   // Monitor: check replies and feed the predictor on every transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected reply status=%0d item=%h last=%b",
                                       rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               seen_reply = replies_due.pop_front();
               if (rsp_tuser !== seen_reply.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_tuser, seen_reply.status));
               if (rsp_tdata !== seen_reply.item)
                  flag_mismatch($sformatf("item %h, want %h", rsp_tdata, seen_reply.item));
               if (rsp_tlast !== seen_reply.last)
                  flag_mismatch($sformatf("last %b, want %b", rsp_tlast, seen_reply.last));
            end
         end
         if (req_tvalid && req_tready) apply_list_op(req_tuser, req_tdata);
      end
   end

   // Driver: change inputs on the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         rsp_tready <= 1'b0;
      end else begin
         // Flip between idling and back-to-back stretches now and then.
         if ($urandom_range(0, 59) == 0) idle_on = !idle_on;

         // Sender: hold the current item until its transfer, then advance.
         if (!req_tvalid || req_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_items[0].drain && replies_due.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               next_cmd = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_cmd.value;
               req_tuser  <= next_cmd.op;
               if (idle_on && pending_items.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 7);
            end
         end

         // Receiver: stall in bursts, never in the tail of the run.
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && pending_items.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
               recv_gap = $urandom_range(1, 7);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int append_pct;
      int r;
      int refilled;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      req_taken     = 1'b0;
      send_gap      = 0;
      recv_gap      = 0;
      idle_on       = 1'b1;
      counted_items = 0;
      mismatches    = 0;
      refilled      = 0;
      append_pct    = 50;

      // Directed: empty list cases, the unused code, extremes, duplicates,
      // head, tail and middle removal, then back to empty.
      add_item(OP_DISPLAY, 32'd0,         1'b0);
      add_item(OP_DELETE,  32'd5,         1'b0);
      add_item(OP_UNUSED,  32'hFFFF_FFFF, 1'b0);
      add_item(OP_APPEND,  32'h8000_0000, 1'b0);
      add_item(OP_APPEND,  32'h7FFF_FFFF, 1'b0);
      add_item(OP_APPEND,  32'h0000_0000, 1'b0);
      add_item(OP_APPEND,  32'hFFFF_FFFF, 1'b0);
      add_item(OP_APPEND,  32'd5,         1'b0);
      add_item(OP_APPEND,  32'd5,         1'b0);
      add_item(OP_APPEND,  32'd7,         1'b0);
      add_item(OP_DISPLAY, 32'd0,         1'b1);
      add_item(OP_DELETE,  32'd5,         1'b0);
      add_item(OP_DELETE,  32'h8000_0000, 1'b0);
      add_item(OP_DELETE,  32'd7,         1'b0);
      add_item(OP_DELETE,  32'd1234,      1'b0);
      add_item(OP_UNUSED,  32'd5,         1'b0);
      add_item(OP_DISPLAY, 32'd0,         1'b0);
      add_item(OP_DELETE,  32'h7FFF_FFFF, 1'b0);
      add_item(OP_DELETE,  32'h0000_0000, 1'b0);
      add_item(OP_DELETE,  32'hFFFF_FFFF, 1'b0);
      add_item(OP_DELETE,  32'd5,         1'b0);
      add_item(OP_DISPLAY, 32'd0,         1'b0);
      add_item(OP_DELETE,  32'h7FFF_FFFF, 1'b0);

      // Run into the full store early, then mix with a drifting op balance.
      queue_fill($urandom_range(2, 6));
      while (counted_items < ITEM_TARGET) begin
         if (counted_items % 25 == 0) append_pct = $urandom_range(20, 75);
         if (!refilled && counted_items >= 250) begin
            queue_fill($urandom_range(2, 6));
            refilled = 1;
         end
         r = $urandom_range(0, 99);
         if (r < append_pct)
            add_item(OP_APPEND, pick_operand(), $urandom_range(0, 49) == 0);
         else if (r < append_pct + 8)
            add_item(OP_DISPLAY, $urandom(), $urandom_range(0, 49) == 0);
         else if (r < append_pct + 11)
            add_item(OP_UNUSED, $urandom(), 1'b0);
         else
            add_item(OP_DELETE, pick_operand(), $urandom_range(0, 49) == 0);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last transfer in, then for every reply out.
      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      guard = 0;
      while (replies_due.size() != 0 && guard < REPLY_WAIT) begin
         @(posedge clock);
         guard++;
      end
      if (replies_due.size() != 0)
         flag_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
      // Catch any stray reply after the last expected one.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ ordered_list_append_delete.f @@
rtl/core/olad_pkg.sv
rtl/core/olad_store.sv
rtl/core/ordered_list_append_delete.sv
bench/ordered_list_append_delete_tb.sv
